### rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// Stable counting sort package
// Shared state encoding, controller command and datapath status types.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int CODE_BITS = 8;
  localparam int PAY_BITS  = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_FLUSH,
    ST_PREFIX,
    ST_PF_DRAIN,
    ST_SCATTER,
    ST_SC_DRAIN,
    ST_EMIT
  } scs_state_t;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic prep;
    logic prefix_step;
    logic scatter_step;
    logic emit;
    logic set_done;
  } scs_cmd_t;

  typedef struct packed {
    logic bidx_last;
    logic cnt_busy;
    logic scatter_done;
    logic sc_busy;
    logic emit_done;
    logic last_taken;
  } scs_stat_t;

endpackage

### rtl/core/scs_ctrl.sv
// ----------------------------------------------------------------------------
// Stable counting sort controller
// Sequences the clearing pass, loading, prefix pass, scatter and emission.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  scs_pkg::scs_stat_t status,
  output scs_pkg::scs_cmd_t  cmd
);

  scs_pkg::scs_state_t state;
  scs_pkg::scs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      scs_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.bidx_last) begin
          state_next = scs_pkg::ST_LOAD;
        end
      end
      scs_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (status.last_taken) begin
          state_next = scs_pkg::ST_FLUSH;
        end
      end
      scs_pkg::ST_FLUSH: begin
        cmd.prep = 1'b1;
        if (!status.cnt_busy) begin
          state_next = scs_pkg::ST_PREFIX;
        end
      end
      scs_pkg::ST_PREFIX: begin
        cmd.prefix_step = 1'b1;
        if (status.bidx_last) begin
          state_next = scs_pkg::ST_PF_DRAIN;
        end
      end
      scs_pkg::ST_PF_DRAIN: begin
        state_next = scs_pkg::ST_SCATTER;
      end
      scs_pkg::ST_SCATTER: begin
        if (status.scatter_done) begin
          state_next = scs_pkg::ST_SC_DRAIN;
        end else begin
          cmd.scatter_step = 1'b1;
        end
      end
      scs_pkg::ST_SC_DRAIN: begin
        if (!status.sc_busy) begin
          state_next = scs_pkg::ST_EMIT;
        end
      end
      scs_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_done) begin
          cmd.set_done = 1'b1;
          state_next   = scs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = scs_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/scs_dpath.sv
// ----------------------------------------------------------------------------
// Stable counting sort datapath
// Item, count, bucket end and sorted memories with their pipelines.
// ----------------------------------------------------------------------------
module scs_dpath #(
  parameter int MAX_ITEMS    = 64,
  parameter int NUM_BUCKETS  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  scs_pkg::scs_cmd_t                 cmd,
  output scs_pkg::scs_stat_t                status,
  input  logic                              item_valid,
  input  logic [scs_pkg::CODE_BITS-1:0]     bucket_code,
  input  logic [scs_pkg::PAY_BITS-1:0]      payload,
  input  logic                              last,
  input  logic                              result_stall,
  output logic                              result_valid,
  output logic [scs_pkg::CODE_BITS-1:0]     out_bucket,
  output logic [scs_pkg::PAY_BITS-1:0]      out_payload,
  output logic                              last_in_bucket,
  output logic                              last_of_set,
  output logic                              dropped
);

  localparam int CB  = scs_pkg::CODE_BITS;
  localparam int PB  = scs_pkg::PAY_BITS;
  localparam int PW  = (PAYLOAD_BITS < PB) ? PAYLOAD_BITS : PB;
  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int IEW = CB + PW;
  localparam int SEW = CB + PW + 1;

  logic [IEW-1:0] item_mem   [MAX_ITEMS];
  logic [CW-1:0]  cnt_mem    [NUM_BUCKETS];
  logic [CW:0]    start_mem  [NUM_BUCKETS];
  logic [SEW-1:0] sorted_mem [MAX_ITEMS];

  logic [CW-1:0]  item_count;
  logic           overflow;
  logic           acc;
  logic           code_ok;
  logic           store;
  logic [BW-1:0]  code_idx;

  logic           s1_v;
  logic           s2_v;
  logic [BW-1:0]  s1_code;
  logic [BW-1:0]  s2_code;
  logic [CW-1:0]  s2_cnt;
  logic [CW-1:0]  cnt_new;
  logic [CW-1:0]  cnt_rd;
  logic           cnt_we;
  logic [BW-1:0]  cnt_wa;
  logic [CW-1:0]  cnt_wd;
  logic [BW-1:0]  cnt_ra;

  logic [BW-1:0]  bidx;
  logic           bidx_last;
  logic           pf_v;
  logic [BW-1:0]  pf_b;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  pf_end;

  logic [CW-1:0]  kidx;
  logic [CW-1:0]  k_dec;
  logic           a_v;
  logic           b_v;
  logic           c_v;
  logic [IEW-1:0] it_rd;
  logic [IEW-1:0] b_item;
  logic [BW-1:0]  a_key;
  logic [BW-1:0]  b_key;
  logic [BW-1:0]  c_key;
  logic [CW-1:0]  c_p;
  logic [CW:0]    st_rd;
  logic           fwd;
  logic [CW-1:0]  ent_end;
  logic           ent_touched;
  logic [CW-1:0]  p;
  logic           st_we;
  logic [BW-1:0]  st_wa;
  logic [CW:0]    st_wd;

  logic           em_load;
  logic           out_v;
  logic [SEW-1:0] out_ent;
  logic           out_los;

  assign acc      = cmd.load & item_valid;
  assign code_ok  = 32'(bucket_code) < 32'(NUM_BUCKETS);
  assign store    = acc & code_ok & (item_count != CW'(MAX_ITEMS));
  assign code_idx = BW'(bucket_code);

  assign cnt_new = (s2_v && (s2_code == s1_code)) ? s2_cnt + CW'(1) : cnt_rd + CW'(1);
  assign pf_end  = pos + cnt_rd;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = bidx;
    cnt_wd = '0;
    if (cmd.clear_step) begin
      cnt_we = 1'b1;
    end else if (pf_v) begin
      cnt_we = 1'b1;
      cnt_wa = pf_b;
    end else if (s1_v) begin
      cnt_we = 1'b1;
      cnt_wa = s1_code;
      cnt_wd = cnt_new;
    end
  end

  assign cnt_ra    = cmd.load ? code_idx : bidx;
  assign bidx_last = bidx == BW'(NUM_BUCKETS - 1);
  assign k_dec     = kidx - CW'(1);

  assign a_key       = BW'(it_rd[IEW-1 -: CB]);
  assign b_key       = BW'(b_item[IEW-1 -: CB]);
  assign fwd         = c_v && (c_key == b_key);
  assign ent_end     = fwd ? c_p : st_rd[CW-1:0];
  assign ent_touched = fwd | st_rd[CW];
  assign p           = ent_end - CW'(1);

  assign st_we = pf_v | b_v;
  assign st_wa = pf_v ? pf_b : b_key;
  assign st_wd = pf_v ? {1'b0, pf_end} : {1'b1, p};

  assign em_load = cmd.emit & (kidx != item_count) & (~out_v | ~result_stall);

  always_ff @(posedge clk) begin
    if (store) begin
      item_mem[item_count[IW-1:0]] <= {bucket_code, payload[PW-1:0]};
    end
    if (cmd.scatter_step) begin
      it_rd <= item_mem[k_dec[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      start_mem[st_wa] <= st_wd;
    end
    st_rd <= start_mem[a_key];
  end

  always_ff @(posedge clk) begin
    if (b_v) begin
      sorted_mem[p[IW-1:0]] <= {b_item, ~ent_touched};
    end
    if (em_load) begin
      out_ent <= sorted_mem[kidx[IW-1:0]];
      out_los <= (kidx + CW'(1)) == item_count;
    end
  end

  always_ff @(posedge clk) begin
    s1_code <= code_idx;
    s2_code <= s1_code;
    s2_cnt  <= cnt_new;
    pf_b    <= bidx;
    b_item  <= it_rd;
    c_key   <= b_key;
    c_p     <= p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      overflow   <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      pf_v       <= 1'b0;
      a_v        <= 1'b0;
      b_v        <= 1'b0;
      c_v        <= 1'b0;
      bidx       <= '0;
      pos        <= '0;
      kidx       <= '0;
      out_v      <= 1'b0;
    end else begin
      if (cmd.set_done) begin
        item_count <= '0;
        overflow   <= 1'b0;
      end else begin
        if (store) begin
          item_count <= item_count + CW'(1);
        end
        if (acc && !store) begin
          overflow <= 1'b1;
        end
      end
      s1_v <= store;
      s2_v <= s1_v;
      pf_v <= cmd.prefix_step;
      a_v  <= cmd.scatter_step;
      b_v  <= a_v;
      c_v  <= b_v;
      if (cmd.clear_step || cmd.prefix_step) begin
        bidx <= bidx_last ? '0 : bidx + BW'(1);
      end
      if (cmd.prep) begin
        pos <= '0;
      end else if (pf_v) begin
        pos <= pf_end;
      end
      if (cmd.prep) begin
        kidx <= item_count;
      end else if (cmd.scatter_step) begin
        kidx <= k_dec;
      end else if (em_load) begin
        kidx <= kidx + CW'(1);
      end
      if (em_load) begin
        out_v <= 1'b1;
      end else if (!result_stall) begin
        out_v <= 1'b0;
      end
    end
  end

  always_comb begin
    status              = '0;
    status.bidx_last    = bidx_last;
    status.cnt_busy     = s1_v;
    status.scatter_done = kidx == CW'(0);
    status.sc_busy      = a_v | b_v;
    status.emit_done    = (kidx == item_count) & ~out_v;
    status.last_taken   = acc & last;
  end

  assign result_valid   = out_v;
  assign out_bucket     = out_ent[SEW-1 -: CB];
  assign out_payload    = PB'(out_ent[PW:1]);
  assign last_in_bucket = out_ent[0];
  assign last_of_set    = out_los;
  assign dropped        = overflow;

endmodule

### rtl/core/stable_counting_sort.sv
// ----------------------------------------------------------------------------
// Stable counting sort
// Loads a set of keyed items and emits their payloads in stable bucket order.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (item_valid, item_stall) and sorted
// requests leave on the result channel (result_valid, result_stall).
// While loading, one item is taken every cycle. Items whose bucket code is
// at or above NUM_BUCKETS, or that arrive once MAX_ITEMS are held, are
// discarded and raise dropped for the whole set.
// The item marked last closes the set and item_stall rises. Then follow a
// flush, a prefix pass over the count memory and a scatter of the stored
// items, each limited by one read and one write per cycle on each memory.
// Results then leave one per cycle from a registered read of the sorted
// memory; result_stall holds the current result and pauses the read.
// After the last result is taken, loading of the next set resumes.
// After reset the count memory is cleared with item_stall high.
// ----------------------------------------------------------------------------
module stable_counting_sort #(
  parameter int MAX_ITEMS    = 64,
  parameter int NUM_BUCKETS  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [scs_pkg::CODE_BITS-1:0] bucket_code,
  input  logic [scs_pkg::PAY_BITS-1:0]  payload,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [scs_pkg::CODE_BITS-1:0] out_bucket,
  output logic [scs_pkg::PAY_BITS-1:0]  out_payload,
  output logic                          last_in_bucket,
  output logic                          last_of_set,
  output logic                          dropped
);

  scs_pkg::scs_cmd_t  cmd;
  scs_pkg::scs_stat_t status;

  scs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  scs_dpath #(
    .MAX_ITEMS    (MAX_ITEMS),
    .NUM_BUCKETS  (NUM_BUCKETS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_valid     (item_valid),
    .bucket_code    (bucket_code),
    .payload        (payload),
    .last           (last),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .out_bucket     (out_bucket),
    .out_payload    (out_payload),
    .last_in_bucket (last_in_bucket),
    .last_of_set    (last_of_set),
    .dropped        (dropped)
  );

  assign item_stall = ~cmd.load;

`ifndef SYNTHESIS
  a_no_load_while_emitting: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("Item channel open while results are pending.");

  a_set_end_closes_bucket: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_set) |-> last_in_bucket)
    else $error("Final result of a set does not close its bucket.");

  a_last_closes_set: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && last) |=> item_stall)
    else $error("Item channel still open after the final item of a set.");
`endif

endmodule

### dv/scs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stable counting sort checker
// Watches both request channels of the sorter. It keeps the items of the open
// set, sorts them stably by bucket when the last one is taken, and compares
// every sorted request leaving the block with the oldest expected one.
// ----------------------------------------------------------------------------
module scs_checker #(
  parameter int MAX_ITEMS    = 64,
  parameter int NUM_BUCKETS  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic [scs_pkg::CODE_BITS-1:0] bucket_code,
  input  logic [scs_pkg::PAY_BITS-1:0]  payload,
  input  logic                          last,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [scs_pkg::CODE_BITS-1:0] out_bucket,
  input  logic [scs_pkg::PAY_BITS-1:0]  out_payload,
  input  logic                          last_in_bucket,
  input  logic                          last_of_set,
  input  logic                          dropped,
  output int                            fails,
  output int                            pending,
  output int                            sets_sorted,
  output int                            full_sets,
  output int                            results_checked
);

  localparam int CB = scs_pkg::CODE_BITS;
  localparam int PB = scs_pkg::PAY_BITS;

  localparam logic [63:0] PAY_MASK =
    (PAYLOAD_BITS >= 64) ? '1 : ((64'(1) << PAYLOAD_BITS) - 64'(1));

  typedef struct packed {
    logic [CB-1:0] bucket;
    logic [PB-1:0] pay;
    logic          bucket_end;
    logic          set_end;
    logic          drop;
  } sorted_req_t;

  logic [CB-1:0] held_codes[$];
  logic [PB-1:0] held_pays[$];
  logic          set_overflow = 1'b0;
  sorted_req_t   sorted_q[$];
  int            n_fail = 0;
  int            n_sets = 0;
  int            n_full = 0;
  int            n_checked = 0;

  function automatic void sort_set();
    int counts[NUM_BUCKETS];
    int taken;
    int n;
    sorted_req_t r;
    n = held_codes.size();
    taken = 0;
    foreach (counts[b]) counts[b] = 0;
    foreach (held_codes[i]) counts[held_codes[i]]++;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      int seen;
      seen = 0;
      if (counts[b] != 0) begin
        foreach (held_codes[i]) begin
          if (held_codes[i] == b) begin
            seen++;
            taken++;
            r.bucket     = CB'(b);
            r.pay        = held_pays[i];
            r.bucket_end = (seen == counts[b]);
            r.set_end    = (taken == n);
            r.drop       = set_overflow;
            sorted_q     = {sorted_q, r};
          end
        end
      end
    end
    held_codes.delete();
    held_pays.delete();
    set_overflow = 1'b0;
  endfunction

  always @(posedge clk) begin
    sorted_req_t want;
    if (rst) begin
      held_codes.delete();
      held_pays.delete();
      sorted_q.delete();
      set_overflow = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (sorted_q.size() == 0) begin
          $error("Sorted request with none expected: bucket %0d payload %h",
                 out_bucket, out_payload);
          n_fail++;
        end else begin
          want = sorted_q.pop_front();
          n_checked++;
          if (out_bucket !== want.bucket) begin
            $error("out_bucket: expected %0d, got %0d", want.bucket, out_bucket);
            n_fail++;
          end
          if (out_payload !== want.pay) begin
            $error("out_payload: expected %h, got %h", want.pay, out_payload);
            n_fail++;
          end
          if (last_in_bucket !== want.bucket_end) begin
            $error("last_in_bucket: expected %b, got %b", want.bucket_end,
                   last_in_bucket);
            n_fail++;
          end
          if (last_of_set !== want.set_end) begin
            $error("last_of_set: expected %b, got %b", want.set_end, last_of_set);
            n_fail++;
          end
          if (dropped !== want.drop) begin
            $error("dropped: expected %b, got %b", want.drop, dropped);
            n_fail++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (int'(bucket_code) >= NUM_BUCKETS || held_codes.size() >= MAX_ITEMS) begin
          set_overflow = 1'b1;
        end else begin
          held_codes = {held_codes, bucket_code};
          held_pays  = {held_pays, payload & PAY_MASK[PB-1:0]};
        end
        if (last) begin
          n_sets++;
          if (set_overflow) n_full++;
          sort_set();
        end
      end
    end
    pending         <= sorted_q.size();
    fails           <= n_fail;
    sets_sorted     <= n_sets;
    full_sets       <= n_full;
    results_checked <= n_checked;
  end

endmodule

### dv/tb_stable_counting_sort.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stable counting sort testbench
// Feeds directed and random sets of keyed items, including overfilled sets,
// under three idle mixes and long result hold-offs; a checker beside the
// block predicts and compares every sorted request.
// ----------------------------------------------------------------------------
module tb_stable_counting_sort;

  localparam int CB           = scs_pkg::CODE_BITS;
  localparam int PB           = scs_pkg::PAY_BITS;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int MAX_ITEMS_TB = 64;

  logic          clk;
  logic          rst;
  logic          item_valid;
  logic          item_stall;
  logic [CB-1:0] bucket_code;
  logic [PB-1:0] payload;
  logic          last;
  logic          result_valid;
  logic          result_stall = 1'b0;
  logic [CB-1:0] out_bucket;
  logic [PB-1:0] out_payload;
  logic          last_in_bucket;
  logic          last_of_set;
  logic          dropped;

  int fails;
  int pending;
  int sets_sorted;
  int full_sets;
  int results_checked;

  int cycles = 0;
  int loaded = 0;
  int snd_idle = 35;
  int rcv_idle = 58;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  stable_counting_sort dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .bucket_code    (bucket_code),
    .payload        (payload),
    .last           (last),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_bucket     (out_bucket),
    .out_payload    (out_payload),
    .last_in_bucket (last_in_bucket),
    .last_of_set    (last_of_set),
    .dropped        (dropped)
  );

  scs_checker chk (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .bucket_code     (bucket_code),
    .payload         (payload),
    .last            (last),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_bucket      (out_bucket),
    .out_payload     (out_payload),
    .last_in_bucket  (last_in_bucket),
    .last_of_set     (last_of_set),
    .dropped         (dropped),
    .fails           (fails),
    .pending         (pending),
    .sets_sorted     (sets_sorted),
    .full_sets       (full_sets),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d sorted requests outstanding.",
               cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // A long hold-off is counted here once the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      result_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic offer(input logic [CB-1:0] code, input logic [PB-1:0] pay,
                       input logic is_last);
    while ($urandom_range(99) < snd_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    bucket_code <= code;
    payload     <= pay;
    last        <= is_last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    loaded++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_set(input int size);
    int mode;
    logic [CB-1:0] base;
    logic [CB-1:0] code;
    mode = $urandom_range(3);
    base = CB'($urandom_range(252));
    for (int i = 0; i < size; i++) begin
      case (mode) inside
        [0:1]: code = CB'($urandom_range(255));
        2: code = base + CB'($urandom_range(3));
        default: code = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      offer(code, $urandom, i == size - 1);
    end
  endtask

  initial begin
    int phase;
    int set_no;
    int start;
    int size;
    rst = 1'b1;
    item_valid = 1'b0;
    bucket_code = '0;
    payload = '0;
    last = 1'b0;
    phase = 0;
    set_no = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer(8'd0, 32'h0000_0000, 1'b1);
    offer(8'd255, 32'hFFFF_FFFF, 1'b1);
    offer(8'd7, 32'hAAAA_AAAA, 1'b0);
    offer(8'd2, 32'h5555_5555, 1'b0);
    offer(8'd7, 32'h0000_0001, 1'b0);
    offer(8'd255, 32'h8000_0000, 1'b0);
    offer(8'd0, 32'hFFFF_FFFE, 1'b0);
    offer(8'd2, 32'h7FFF_FFFF, 1'b0);
    offer(8'd7, 32'h1234_5678, 1'b1);
    offer(8'd200, 32'h8000_0001, 1'b0);
    offer(8'd150, 32'h4000_0002, 1'b0);
    offer(8'd100, 32'h2000_0004, 1'b0);
    offer(8'd50, 32'h1000_0008, 1'b0);
    offer(8'd1, 32'h0800_0010, 1'b1);
    offer(8'd128, 32'h0000_0001, 1'b0);
    offer(8'd128, 32'h0000_0002, 1'b0);
    offer(8'd128, 32'h0000_0003, 1'b1);
    drain();

    start = loaded;
    while (loaded - start < RANDOM_ITEMS) begin
      if (phase == 0 && loaded - start >= 150) begin
        drain();
        phase = 1;
        set_no = 0;
        snd_idle = 58;
        rcv_idle <= 35;
      end else if (phase == 1 && loaded - start >= 300) begin
        drain();
        phase = 2;
        set_no = 0;
        snd_idle = 0;
        rcv_idle <= 0;
      end
      set_no++;
      // Full sets fill or run past the capacity of the block, sometimes dropping the
      // item that closes the set.
      if ((phase == 0 && set_no == 3) || (phase == 2 && set_no == 3))
        size = $urandom_range(MAX_ITEMS_TB + 4, MAX_ITEMS_TB);
      else if ($urandom_range(9) == 0)
        size = 1;
      else
        size = $urandom_range(16, 2);
      random_set(size);
      if (phase == 2 && (set_no == 1 || set_no == 5))
        hold_reqs <= hold_reqs + 1;
      else if ($urandom_range(7) == 0)
        drain();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Loaded %0d requests in %0d sets (%0d overfilled) under three idle mixes",
             loaded, sets_sorted, full_sets);
    $display("and %0d long result hold-offs; %0d sorted requests compared field by field.",
             hold_served, results_checked);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
